/* rtl/double_ended_queue_unit_macros.svh */
// assertion helpers for the deque unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// condition must hold in the same cycle
`define DEQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/deq_pkg.sv */
package deq_pkg;

    localparam int KIND_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [KIND_W-1:0]          kind_t;
    typedef logic signed [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0]        status_t;

    // command kinds
    localparam kind_t KIND_PUSH_HEAD = 3'd0;
    localparam kind_t KIND_PUSH_TAIL = 3'd1;
    localparam kind_t KIND_POP_HEAD  = 3'd2;
    localparam kind_t KIND_POP_TAIL  = 3'd3;
    localparam kind_t KIND_PEEK_HEAD = 3'd4;
    localparam kind_t KIND_PEEK_TAIL = 3'd5;
    localparam kind_t KIND_CONTAINS  = 3'd6;

    // result status codes
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

/* rtl/deq_ram.sv */
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/double_ended_queue_unit.sv */
// Bounded double-ended queue of signed 32-bit words. The words sit in a
// circular store of DEPTH entries (one synchronous RAM, one write and one
// read port, registered read data); a head pointer and an occupancy count
// in flip-flops locate them. Each command transaction on the s_ channel
// (push head/tail, pop head/tail, peek head/tail, contains) yields exactly
// one result transaction on the m_ channel carrying data, status (ok, empty,
// full) and a found flag. Commands are handled one at a time. Pushes,
// failed pops/peeks, empty contains and unknown kinds go straight to the
// result stage; successful pops and peeks first wait for one RAM read;
// contains reads the held words from the head, up to and including the
// first match (at most the occupancy, so at most DEPTH words). The
// contains scan is paced by the single RAM read port, one entry per cycle.
// The result sits in an output register, so the block accepts the next
// command while an earlier result still waits. The store needs no clearing
// after reset: only held entries are read, and each was written by a push.
// Reset is synchronous and active low.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  deq_pkg::kind_t        s_kind,
    input  deq_pkg::data_t        s_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output deq_pkg::data_t        m_data,
    output deq_pkg::status_t      m_status,
    output logic                  m_found
);

    // widths derived from the depth
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a command
    localparam logic [1:0] ST_RDATA = 2'd1;  // pop or peek read in flight
    localparam logic [1:0] ST_SCAN  = 2'd2;  // contains walking the store
    localparam logic [1:0] ST_OUT   = 2'd3;  // result waiting for output reg

    logic [1:0]         state_reg,     state_next;
    logic [IDX_W-1:0]   head_reg,      head_next;
    logic [CNT_W-1:0]   occ_reg,       occ_next;
    logic [IDX_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]   scan_cnt_reg,  scan_cnt_next;
    deq_pkg::data_t     value_reg,     value_next;
    deq_pkg::data_t     res_data_reg,  res_data_next;
    deq_pkg::status_t   res_status_reg, res_status_next;
    logic               res_found_reg, res_found_next;
    logic               m_valid_reg,   m_valid_next;
    deq_pkg::data_t     m_data_reg,    m_data_next;
    deq_pkg::status_t   m_status_reg,  m_status_next;
    logic               m_found_reg,   m_found_next;

    // store port signals
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [deq_pkg::DATA_W-1:0] wr_data;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [deq_pkg::DATA_W-1:0] rd_data;

    // pointer arithmetic, all modulo DEPTH
    logic [SUM_W-1:0]   tail_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [IDX_W-1:0]   tail_push_idx;
    logic [IDX_W-1:0]   tail_last_idx;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   head_inc;
    logic [IDX_W-1:0]   scan_inc;
    logic               is_full;
    logic               is_empty;
    logic               s_accept;
    logic               out_free;
    logic               full_push;
    logic               scanning;

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // slot just past the tail, and the tail slot itself
    assign tail_sum      = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign last_sum      = tail_sum - SUM_W'(1);
    assign tail_push_idx = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                                   : IDX_W'(tail_sum);
    assign tail_last_idx = (last_sum >= DEPTH_SUM) ? IDX_W'(last_sum - DEPTH_SUM)
                                                   : IDX_W'(last_sum);
    assign head_dec = (head_reg == '0)       ? LAST_IDX : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0       : head_reg + IDX_W'(1);
    assign scan_inc = (scan_addr_reg == LAST_IDX) ? '0 : scan_addr_reg + IDX_W'(1);

    assign is_full  = (occ_reg == DEPTH_CNT);
    assign is_empty = (occ_reg == '0);

    // push taken while the store is full, and the contains walk in progress
    assign full_push = s_accept && is_full &&
                       (s_kind == deq_pkg::KIND_PUSH_HEAD || s_kind == deq_pkg::KIND_PUSH_TAIL);
    assign scanning  = (state_reg == ST_SCAN);

    // commands are taken only between transactions; results leave through
    // the output register so a waiting result does not block the next one
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        scan_addr_next  = scan_addr_reg;
        scan_cnt_next   = scan_cnt_reg;
        value_next      = value_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = s_value;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        // result taken by the sink
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    value_next      = s_value;
                    res_data_next   = '0;
                    res_status_next = deq_pkg::STATUS_OK;
                    res_found_next  = 1'b0;
                    state_next      = ST_OUT;
                    case (s_kind)
                        deq_pkg::KIND_PUSH_HEAD: begin
                            if (is_full) begin
                                res_status_next = deq_pkg::STATUS_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = head_dec;
                                head_next = head_dec;
                                occ_next  = occ_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::KIND_PUSH_TAIL: begin
                            if (is_full) begin
                                res_status_next = deq_pkg::STATUS_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = tail_push_idx;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::KIND_POP_HEAD, deq_pkg::KIND_PEEK_HEAD: begin
                            if (is_empty) begin
                                res_status_next = deq_pkg::STATUS_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = ST_RDATA;
                                if (s_kind == deq_pkg::KIND_POP_HEAD) begin
                                    head_next = head_inc;
                                    occ_next  = occ_reg - CNT_W'(1);
                                end
                            end
                        end
                        deq_pkg::KIND_POP_TAIL, deq_pkg::KIND_PEEK_TAIL: begin
                            if (is_empty) begin
                                res_status_next = deq_pkg::STATUS_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = tail_last_idx;
                                state_next = ST_RDATA;
                                if (s_kind == deq_pkg::KIND_POP_TAIL) begin
                                    occ_next = occ_reg - CNT_W'(1);
                                end
                            end
                        end
                        deq_pkg::KIND_CONTAINS: begin
                            // start the walk at the head word
                            if (!is_empty) begin
                                rd_en          = 1'b1;
                                rd_addr        = head_reg;
                                scan_addr_next = head_reg;
                                scan_cnt_next  = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: begin
                            // unknown kind: plain ok result
                        end
                    endcase
                end
            end
            ST_RDATA: begin
                res_data_next = deq_pkg::data_t'(rd_data);
                state_next    = ST_OUT;
            end
            ST_SCAN: begin
                // rd_data holds entry number scan_cnt_reg counted from the head
                if (rd_data == value_reg) begin
                    res_found_next = 1'b1;
                    state_next     = ST_OUT;
                end else if (scan_cnt_reg == occ_reg - CNT_W'(1)) begin
                    state_next = ST_OUT;
                end else begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_inc;
                    scan_addr_next = scan_inc;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_data_reg;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        scan_addr_reg  <= scan_addr_next;
        scan_cnt_reg   <= scan_cnt_next;
        value_reg      <= value_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;

    // occupancy never exceeds the store
    `DEQ_ASSERT_SAME(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= DEPTH_CNT, "occupancy overrun")
    // head pointer stays inside the store
    `DEQ_ASSERT_SAME(a_head_bound, aclk, aresetn, 1'b1, head_reg <= LAST_IDX, "head out of range")
    // a push on a full queue leaves the occupancy alone
    `DEQ_ASSERT_NEXT(a_full_push, aclk, aresetn, full_push, $stable(occ_reg), "full push moved occupancy")
    // the contains walk never passes the held words
    `DEQ_ASSERT_SAME(a_scan_bound, aclk, aresetn, scanning, scan_cnt_reg < occ_reg, "scan past tail")

endmodule
